// ===== hdl/sft_pkg.sv =====
`default_nettype none

package sft_pkg;

  localparam int SFT_GRID_SIZE   = 8;
  localparam int SFT_SETUP_BYTES = 4;

  localparam logic [7:0] HDR_SETUP = 8'h56;
  localparam logic [7:0] HDR_IMAGE = 8'h89;
  localparam logic [7:0] WB_FLAG   = 8'h80;
  localparam logic [7:0] WB_MAX    = 8'h3F;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_IMAGE = 3'd2;
  localparam logic [2:0] OP_WB    = 3'd3;
  localparam logic [2:0] OP_SLEEP = 3'd4;
  localparam logic [2:0] OP_WAKE  = 3'd5;

  localparam int         CFG_IDX_W  = 1;
  localparam logic [0:0] REG_ORIENT = 1'd0;
  localparam logic [0:0] REG_SLEEP  = 1'd1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FIRST = 3'd1,
    PH_SLOT  = 3'd2,
    PH_LINE  = 3'd3,
    PH_SETUP = 3'd4,
    PH_END   = 3'd5,
    PH_SENT  = 3'd6
  } phase_t;

  typedef struct packed {
    logic       ready_out;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       pix_sel;
    logic [2:0] phase;
    logic       sleeping;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/sft_ctrl.sv =====
`default_nettype none

module sft_ctrl
  import sft_pkg::*;
#(
  parameter int GRID_SIZE   = SFT_GRID_SIZE,
  parameter int SETUP_BYTES = SFT_SETUP_BYTES,
  parameter int ADDR_W      = $clog2(GRID_SIZE * GRID_SIZE * 3)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire logic [2:0]           op,
  input  wire logic                 rdy,
  input  wire logic                 empty,
  input  wire logic [7:0]           red_level,
  input  wire logic [7:0]           green_level,
  input  wire logic [7:0]           blue_level,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [31:0]          cfg_wdata,
  output res_t                      res,
  output logic                      rd_en,
  output logic [ADDR_W-1:0]         rd_addr
);

  localparam int LCW = $clog2(GRID_SIZE + 1);
  localparam int CW  = $clog2(GRID_SIZE);
  localparam int SIW = $clog2(SETUP_BYTES + 1);
  localparam logic [LCW-1:0] TOP = LCW'(GRID_SIZE - 1);

  phase_t         state_r, state_nxt;
  logic [LCW-1:0] line_r, line_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [1:0]     ch_r, ch_nxt;
  logic [SIW-1:0] idx_r, idx_nxt;
  logic [SIW-1:0] idx_evt;
  logic           img_r, img_nxt;
  logic           set_r, set_nxt;
  logic           asleep_r, asleep_nxt;
  logic [7:0]     bytes_r [SETUP_BYTES];
  logic [7:0]     bytes_nxt [SETUP_BYTES];
  logic [1:0]     orient_r;
  logic [31:0]    sleep_pat_r;
  logic [7:0]     lv [3];
  logic [7:0]     setup_byte;
  logic [LCW-1:0] rot_r, rot_k, ext_col;
  logic           pix_oob;

  assign lv[0] = red_level;
  assign lv[1] = green_level;
  assign lv[2] = blue_level;

  // rotated read position from the line and column counters
  assign ext_col = LCW'(col_r);
  assign pix_oob = (32'(line_r) >= GRID_SIZE);

  always_comb begin
    case (orient_r)
      2'd1: begin
        rot_r = TOP - ext_col;
        rot_k = line_r;
      end
      2'd2: begin
        rot_r = TOP - line_r;
        rot_k = TOP - ext_col;
      end
      2'd3: begin
        rot_r = ext_col;
        rot_k = TOP - line_r;
      end
      default: begin
        rot_r = line_r;
        rot_k = ext_col;
      end
    endcase
  end

  assign rd_addr = ADDR_W'((ADDR_W'(rot_r) * ADDR_W'(GRID_SIZE) + ADDR_W'(rot_k)) * ADDR_W'(3)
                           + ADDR_W'(ch_r));

  // setup index as left by this beat's request, before the send advances it
  assign idx_evt = (op == OP_WB || op == OP_SLEEP) ? '0 : idx_r;

  always_comb begin
    setup_byte = 8'd0;
    for (int i = 0; i < SETUP_BYTES; i++) begin
      if (32'(idx_evt) == i) begin
        setup_byte = bytes_nxt[i];
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    ch_nxt     = ch_r;
    idx_nxt    = idx_r;
    img_nxt    = img_r;
    set_nxt    = set_r;
    asleep_nxt = asleep_r;
    bytes_nxt  = bytes_r;
    res        = '0;
    rd_en      = 1'b0;

    if (op == OP_WAKE) begin
      asleep_nxt    = 1'b0;
      res.ready_out = 1'b1;
    end else begin
      case (op)
        OP_IMAGE: begin
          img_nxt = 1'b1;
        end
        OP_WB: begin
          idx_nxt      = '0;
          bytes_nxt[0] = bytes_r[0] | WB_FLAG;
          for (int i = 1; i < SETUP_BYTES; i++) begin
            if (i < 4) begin
              bytes_nxt[i] = lv[(i + 2) % 3];
            end
          end
          set_nxt = 1'b1;
        end
        OP_SLEEP: begin
          idx_nxt = '0;
          for (int i = 0; i < SETUP_BYTES; i++) begin
            if (i < 4) begin
              bytes_nxt[i] = sleep_pat_r[8*(i%4) +: 8];
            end else begin
              bytes_nxt[i] = 8'd0;
            end
          end
          set_nxt = 1'b1;
        end
        default: begin
        end
      endcase

      if (!asleep_r) begin
        res.ready_out = 1'b1;
        case (state_r)
          PH_IDLE: begin
            res.ready_out = 1'b0;
            if ((img_nxt || set_nxt) && rdy) begin
              state_nxt = PH_FIRST;
            end
          end
          PH_FIRST: begin
            if (!rdy && empty) begin
              res.tx_valid = 1'b1;
              if (set_nxt) begin
                set_nxt     = 1'b0;
                res.tx_byte = HDR_SETUP;
                state_nxt   = PH_SETUP;
              end else begin
                img_nxt     = 1'b0;
                res.tx_byte = HDR_IMAGE;
                state_nxt   = PH_LINE;
              end
            end
          end
          PH_SLOT: begin
            if (!rdy) begin
              state_nxt = PH_LINE;
            end
          end
          PH_LINE: begin
            if (empty) begin
              res.tx_valid = 1'b1;
              res.pix_sel  = !pix_oob;
              rd_en        = !pix_oob;
              if (ch_r == 2'd2) begin
                ch_nxt = 2'd0;
                if (32'(col_r) == GRID_SIZE - 1) begin
                  col_nxt   = '0;
                  line_nxt  = line_r + 1'b1;
                  state_nxt = PH_END;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end else begin
                ch_nxt = ch_r + 2'd1;
              end
            end
          end
          PH_SETUP: begin
            if (empty) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = setup_byte;
              idx_nxt      = idx_nxt + 1'b1;
              if (32'(idx_nxt) >= SETUP_BYTES) begin
                line_nxt = LCW'(GRID_SIZE);
                if (bytes_nxt[0] == sleep_pat_r[7:0]) begin
                  state_nxt = PH_SENT;
                end else begin
                  state_nxt = PH_END;
                end
              end
            end
          end
          PH_END: begin
            if (rdy) begin
              if (32'(line_r) >= GRID_SIZE) begin
                line_nxt      = '0;
                idx_nxt       = '0;
                res.ready_out = 1'b0;
                state_nxt     = PH_IDLE;
              end else begin
                state_nxt = PH_SLOT;
              end
            end
          end
          PH_SENT: begin
            if (empty) begin
              asleep_nxt = 1'b1;
              line_nxt   = '0;
              idx_nxt    = '0;
              state_nxt  = PH_IDLE;
            end
          end
          default: begin
            res.ready_out = 1'b0;
            line_nxt      = '0;
            col_nxt       = '0;
            ch_nxt        = '0;
            idx_nxt       = '0;
            state_nxt     = PH_IDLE;
          end
        endcase
      end
    end

    res.sleeping = asleep_nxt;
    res.phase    = asleep_nxt ? PH_IDLE : state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_IDLE;
      line_r      <= '0;
      col_r       <= '0;
      ch_r        <= '0;
      idx_r       <= '0;
      img_r       <= 1'b0;
      set_r       <= 1'b0;
      asleep_r    <= 1'b0;
      orient_r    <= '0;
      sleep_pat_r <= '0;
      for (int i = 0; i < SETUP_BYTES; i++) begin
        bytes_r[i] <= 8'd0;
      end
    end else begin
      if (fire) begin
        state_r  <= state_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        ch_r     <= ch_nxt;
        idx_r    <= idx_nxt;
        img_r    <= img_nxt;
        set_r    <= set_nxt;
        asleep_r <= asleep_nxt;
        bytes_r  <= bytes_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_ORIENT: orient_r    <= cfg_wdata[1:0];
          REG_SLEEP:  sleep_pat_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/slot_frame_transmitter_top.sv =====
// channel | dir | tvalid/tready       | payload
// in      | in  | in_tvalid/in_tready | tuser operation, tdata 42 bits in 48
// out     | out | out_tvalid/out_tready | tdata 14 bits in 16, one beat per in beat
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data; cfg_ready always high
//
// one beat per cycle but for back-pressure; results show the cycle after acceptance
// the pixel store is a single-port-write, single-read memory with registered read;
// a write and a pixel read of the same entry in one beat are forwarded
// in_tready follows out_tready while the output register is full
// synchronous active-low reset clears all control state; the pixel store is not cleared
`default_nettype none

module slot_frame_transmitter_top
  import sft_pkg::*;
#(
  parameter int GRID_SIZE   = SFT_GRID_SIZE,
  parameter int SETUP_BYTES = SFT_SETUP_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // operation
  input  wire logic [2:0]           in_tuser,
  // ready_in, tx_empty, row[3], column[3], channel[2], pixel_value[8],
  // red_level[8], green_level[8], blue_level[8], zero pad
  input  wire logic [47:0]          in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // ready_out, tx_valid, tx_byte[8], phase[3], sleeping, zero pad
  output logic [15:0]               out_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int DEPTH  = GRID_SIZE * GRID_SIZE * 3;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              in_fire;
  res_t              res;
  res_t              res_r;
  logic              out_valid_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [2:0]        wr_row, wr_col;
  logic [1:0]        wr_ch;
  logic [7:0]        wr_data;
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata_r;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;
  logic [7:0]        tx_byte;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  sft_ctrl #(
    .GRID_SIZE  (GRID_SIZE),
    .SETUP_BYTES(SETUP_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .op         (in_tuser),
    .rdy        (in_tdata[0]),
    .empty      (in_tdata[1]),
    .red_level  (in_tdata[25:18]),
    .green_level(in_tdata[33:26]),
    .blue_level (in_tdata[41:34]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .res        (res),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  assign wr_row  = in_tdata[4:2];
  assign wr_col  = in_tdata[7:5];
  assign wr_ch   = in_tdata[9:8];
  assign wr_data = in_tdata[17:10];
  assign wr_en   = in_fire && (in_tuser == OP_WRITE) && (32'(wr_row) < GRID_SIZE)
                   && (32'(wr_col) < GRID_SIZE) && (wr_ch < 2'd3);
  assign wr_addr = ADDR_W'((ADDR_W'(wr_row) * ADDR_W'(GRID_SIZE) + ADDR_W'(wr_col))
                           * ADDR_W'(3) + ADDR_W'(wr_ch));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_fire && rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  always_comb begin
    if (res_r.pix_sel) begin
      tx_byte = fwd_r ? fwd_data_r : rdata_r;
    end else begin
      tx_byte = res_r.tx_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.sleeping, res_r.phase, tx_byte,
                       res_r.tx_valid, res_r.ready_out};

  a_no_byte_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tdata[1] |=> !res_r.tx_valid)
    else $error("byte sent while transmitter full");

  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && wr_en && rd_en && (wr_addr == rd_addr) |=> fwd_r)
    else $error("same-entry write not forwarded");

  a_pix_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.pix_sel |-> res_r.tx_valid && !res_r.sleeping)
    else $error("pixel byte without a send");

  a_sleep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.sleeping |-> !res_r.tx_valid && (res_r.phase == PH_IDLE))
    else $error("asleep but machine active");

endmodule

`default_nettype wire
